[rtl/hcmh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcmh_pkg: shared constants and types for the huffman cost min-heap
// Field widths of the stream words, parameter defaults and the status
// struct that the compare unit hands back to the sequencer.
// ---------------------------------------------------------------------------
package hcmh_pkg;

	// parameter defaults
	localparam int DEF_MAX_SYMBOLS = 64;
	localparam int DEF_WEIGHT_BITS = 16;

	// fixed field widths of the stream words
	localparam int WEIGHT_IN_BITS = 16;
	localparam int COST_BITS      = 32;
	localparam int SYMCNT_BITS    = 7;
	localparam int OUT_DATA_BITS  = 40;

	// status of the shared compare and add unit
	typedef struct packed {
		logic pick_b;  // second candidate is valid and strictly smaller than the first
		logic key_gt;  // key is greater than the smaller candidate
		logic key_lt;  // key is less than the smaller candidate
	} cmp_flags_t;

endpackage : hcmh_pkg
`default_nettype wire

[rtl/hcmh_heap_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcmh_heap_ram: heap storage
// One write port and two read ports, read data registered. Contents are
// undefined until written.
// ---------------------------------------------------------------------------
module hcmh_heap_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 22
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr_a,
	input  wire logic [AW-1:0] rd_addr_b,
	output logic      [DW-1:0] rd_data_a,
	output logic      [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule : hcmh_heap_ram
`default_nettype wire

[rtl/hcmh_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcmh_alu: shared compare and add unit
// Picks the smaller of two heap entries, compares the moving key against
// it and forms the sum of the key and the first entry.
// ---------------------------------------------------------------------------
module hcmh_alu #(
	parameter int DW = 22
) (
	input  wire logic [DW-1:0]      key,
	input  wire logic [DW-1:0]      cand_a,
	input  wire logic [DW-1:0]      cand_b,
	input  wire logic               b_ok,
	output hcmh_pkg::cmp_flags_t    flags,
	output logic      [DW-1:0]      min_val,
	output logic      [DW-1:0]      sum
);

	// smaller candidate, then key against it
	always_comb begin
		flags.pick_b = b_ok && (cand_b < cand_a);
		min_val      = flags.pick_b ? cand_b : cand_a;
		flags.key_gt = key > min_val;
		flags.key_lt = key < min_val;
	end

	// merge sum
	assign sum = key + cand_a;

endmodule : hcmh_alu
`default_nettype wire

[rtl/huffman_cost_min_heap.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// huffman_cost_min_heap: huffman weighted path length by binary min-heap
// Weights stream in and are sifted into a heap; the word marked last closes
// the set, after which the two smallest entries are merged until one is left
// and the sum of all merges is returned with the symbol count and overflow flag.
// ---------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                          tlast
//  s_axis   in   weight[15:0]                                last
//  m_axis   out  path_cost[31:0], symbol_count[38:32],       -
//                overflowed[39]
//
// Sequence: a weight is sifted up, one heap level per parent read and
// compare, in the sift-up loop around one heap memory read port; the first
// weight of a set goes straight to the root. A closing word then starts
// N-1 merges for N symbols, each sift-down level being one two-port read
// and one compare.
// Reset: arst_n low clears the count, cost, flags and sequencer at once; the
// heap memory is not cleared and needs no sweep.
// Stalls: a result waits in the output register while new weights are taken;
// a set that closes while that register is full waits for it to drain.
module huffman_cost_min_heap #(
	parameter int MAX_SYMBOLS = hcmh_pkg::DEF_MAX_SYMBOLS,
	parameter int WEIGHT_BITS = hcmh_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [hcmh_pkg::WEIGHT_IN_BITS-1:0]   s_axis_tdata,  // weight
	input  wire logic                                  s_axis_tlast,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// path_cost, symbol_count, overflowed
	output logic      [hcmh_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

	localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
	localparam int AW         = $clog2(MAX_SYMBOLS);
	localparam int ENTRY_BITS = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int WIN        = hcmh_pkg::WEIGHT_IN_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_MCHK,
		S_MPOP,
		S_SD,
		S_SD_CMP,
		S_MTOP,
		S_MADD,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               idx_q;
	logic [CNT_W-1:0]               acc_q;
	logic [hcmh_pkg::COST_BITS-1:0] cost_q;
	logic                           ovf_q;
	logic                           last_q;
	logic                           sd_replace_q;
	logic [ENTRY_BITS-1:0]          key_q;
	logic [ENTRY_BITS-1:0]          sum_a_q;
	logic                           out_valid_q;
	logic [hcmh_pkg::OUT_DATA_BITS-1:0] out_data_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_wa;
	logic [ENTRY_BITS-1:0] ram_wd;
	logic [AW-1:0]         ram_ra;
	logic [AW-1:0]         ram_rb;
	logic [ENTRY_BITS-1:0] rd_a;
	logic [ENTRY_BITS-1:0] rd_b;

	hcmh_pkg::cmp_flags_t  flags;
	logic [ENTRY_BITS-1:0] alu_key;
	logic [ENTRY_BITS-1:0] min_val;
	logic [ENTRY_BITS-1:0] sum;
	logic                  alu_b_ok;

	logic [ENTRY_BITS+WIN-1:0] w_wide;
	logic [ENTRY_BITS-1:0]     w_ext;
	logic [CNT_W:0]            count_ext;
	logic [CNT_W:0]            lc;
	logic [CNT_W:0]            rc;
	logic                      has_l;
	logic                      has_r;
	logic [CNT_W-1:0]          c_w;
	logic [CNT_W:0]            nlc;
	logic [CNT_W:0]            nrc;
	logic                      has_nl;
	logic                      has_nr;
	logic [CNT_W-1:0]          par;
	logic [CNT_W-1:0]          gpar;
	logic                      in_fire;

	// 1-based heap index to memory address
	function automatic logic [AW-1:0] to_addr(input logic [CNT_W:0] x);
		logic [CNT_W:0] d;
		d = x - 1'b1;
		return d[AW-1:0];
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// weight masked to the configured width
	always_comb begin
		w_wide = {{ENTRY_BITS{1'b0}}, s_axis_tdata};
		for (int j = 0; j < ENTRY_BITS; j++) begin
			w_ext[j] = (j < WEIGHT_BITS) ? w_wide[j] : 1'b0;
		end
	end

	// child and parent indices of the current hole
	always_comb begin
		count_ext = {1'b0, count_q};
		lc        = {idx_q, 1'b0};
		rc        = lc + 1'b1;
		has_l     = lc <= count_ext;
		has_r     = rc <= count_ext;
		c_w       = flags.pick_b ? rc[CNT_W-1:0] : lc[CNT_W-1:0];
		nlc       = {c_w, 1'b0};
		nrc       = nlc + 1'b1;
		has_nl    = nlc <= count_ext;
		has_nr    = nrc <= count_ext;
		par       = idx_q >> 1;
		gpar      = idx_q >> 2;
	end

	// shared unit operands
	assign alu_key  = (state_q == S_MADD) ? sum_a_q : key_q;
	assign alu_b_ok = (state_q == S_SD_CMP) && has_r;

	hcmh_alu #(
		.DW (ENTRY_BITS)
	) u_alu (
		.key     (alu_key),
		.cand_a  (rd_a),
		.cand_b  (rd_b),
		.b_ok    (alu_b_ok),
		.flags   (flags),
		.min_val (min_val),
		.sum     (sum)
	);

	// heap memory port drive
	always_comb begin
		ram_we = 1'b0;
		ram_wa = to_addr({1'b0, idx_q});
		ram_wd = key_q;
		ram_ra = '0;
		ram_rb = '0;
		unique case (state_q)
			S_UP: begin
				if (idx_q == CNT_W'(1)) begin
					ram_we = 1'b1;
				end else begin
					ram_ra = to_addr({1'b0, par});
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (flags.key_lt) begin
					ram_wd = rd_a;
					ram_ra = to_addr({1'b0, gpar});
				end
			end
			S_MCHK: begin
				ram_rb = to_addr(count_ext);
			end
			S_SD: begin
				if (has_l) begin
					ram_ra = to_addr(lc);
					ram_rb = has_r ? to_addr(rc) : to_addr(lc);
				end else begin
					ram_we = 1'b1;
				end
			end
			S_SD_CMP: begin
				ram_we = 1'b1;
				if (flags.key_gt) begin
					ram_wd = min_val;
					ram_ra = to_addr(nlc);
					ram_rb = has_nr ? to_addr(nrc) : to_addr(nlc);
				end
			end
			S_IDLE, S_MPOP, S_MTOP, S_MADD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	hcmh_heap_ram #(
		.DEPTH (MAX_SYMBOLS),
		.AW    (AW),
		.DW    (ENTRY_BITS)
	) u_ram (
		.clk       (clk),
		.wr_en     (ram_we),
		.wr_addr   (ram_wa),
		.wr_data   (ram_wd),
		.rd_addr_a (ram_ra),
		.rd_addr_b (ram_rb),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			acc_q        <= '0;
			cost_q       <= '0;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
			sd_replace_q <= 1'b0;
			key_q        <= '0;
			sum_a_q      <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= s_axis_tlast;
						if (count_q < CNT_W'(MAX_SYMBOLS)) begin
							count_q <= count_q + 1'b1;
							idx_q   <= count_q + 1'b1;
							key_q   <= w_ext;
							state_q <= S_UP;
						end else begin
							ovf_q <= 1'b1;
							if (s_axis_tlast) begin
								acc_q   <= count_q;
								state_q <= S_MCHK;
							end
						end
					end
				end
				S_UP: begin
					if (idx_q == CNT_W'(1)) begin
						if (last_q) begin
							acc_q   <= count_q;
							state_q <= S_MCHK;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (flags.key_lt) begin
						idx_q <= par;
						if (par == CNT_W'(1)) begin
							state_q <= S_UP;
						end
					end else if (last_q) begin
						acc_q   <= count_q;
						state_q <= S_MCHK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MCHK: begin
					state_q <= (count_q > CNT_W'(1)) ? S_MPOP : S_DONE;
				end
				S_MPOP: begin
					sum_a_q      <= rd_a;
					key_q        <= rd_b;
					count_q      <= count_q - 1'b1;
					idx_q        <= CNT_W'(1);
					sd_replace_q <= 1'b0;
					state_q      <= S_SD;
				end
				S_SD: begin
					if (has_l) begin
						state_q <= S_SD_CMP;
					end else begin
						state_q <= sd_replace_q ? S_MCHK : S_MTOP;
					end
				end
				S_SD_CMP: begin
					if (flags.key_gt) begin
						idx_q <= c_w;
						if (!has_nl) begin
							state_q <= S_SD;
						end
					end else begin
						state_q <= sd_replace_q ? S_MCHK : S_MTOP;
					end
				end
				S_MTOP: begin
					state_q <= S_MADD;
				end
				S_MADD: begin
					key_q        <= sum;
					cost_q       <= cost_q + hcmh_pkg::COST_BITS'(sum);
					idx_q        <= CNT_W'(1);
					sd_replace_q <= 1'b1;
					state_q      <= S_SD;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {ovf_q, hcmh_pkg::SYMCNT_BITS'(acc_q), cost_q};
						out_valid_q <= 1'b1;
						count_q     <= '0;
						cost_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// heap never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SYMBOLS))
		else $error("heap count above depth");

	// no heap write while waiting for a word
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !ram_we)
		else $error("heap written while idle");

	// a new result only comes out of the done state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	// sift-down writes stay inside the live heap
	a_sd_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SD_CMP && ram_we) |-> (idx_q <= count_q))
		else $error("sift-down write beyond heap count");

	// the merge add does not change the entry count
	a_merge_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MADD) |=> $stable(count_q))
		else $error("count changed across merge add");

endmodule : huffman_cost_min_heap
`default_nettype wire

[test/tb_huffman_cost_min_heap.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_huffman_cost_min_heap: stream test of the huffman cost min-heap
// Weight sets are streamed in with random gaps and output stalls. A
// scoreboard works out the optimal merge cost, symbol count and overflow
// flag of each closed set and checks every output word against them in order.
// ---------------------------------------------------------------------------
module tb_huffman_cost_min_heap;

	localparam int HEAP_DEPTH    = hcmh_pkg::DEF_MAX_SYMBOLS;
	localparam int W_BITS        = hcmh_pkg::WEIGHT_IN_BITS;
	localparam int IDLE_LIMIT    = 20000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam int REPORT_MAX    = 10;
	localparam int ITEM_TARGET   = 450;

	typedef struct {
		logic [hcmh_pkg::COST_BITS-1:0]   cost;
		logic [hcmh_pkg::SYMCNT_BITS-1:0] count;
		logic                             ovf;
	} set_result_t;

	// predicts the result of each closed weight set and checks output words
	class path_cost_book;
		logic [W_BITS-1:0] set_weights[$];
		bit                set_dropped;
		set_result_t       owed[$];
		int                errors;

		// total of all pair sums when the two lightest entries are merged each time
		function logic [31:0] merge_cost();
			longint unsigned pool[$];
			longint unsigned lo_a, lo_b, total;
			total = 0;
			foreach (set_weights[i]) pool.push_back(longint'(set_weights[i]));
			while (pool.size() > 1) begin
				pool.sort();
				lo_a = pool.pop_front();
				lo_b = pool.pop_front();
				total += lo_a + lo_b;
				pool.push_back(lo_a + lo_b);
			end
			return total[31:0];
		endfunction

		function void note_weight(logic [W_BITS-1:0] w, logic closing);
			set_result_t r;
			if (set_weights.size() < HEAP_DEPTH)
				set_weights.push_back(w);
			else
				set_dropped = 1'b1;
			if (closing) begin
				r.cost  = merge_cost();
				r.count = hcmh_pkg::SYMCNT_BITS'(set_weights.size());
				r.ovf   = set_dropped;
				owed.push_back(r);
				set_weights.delete();
				set_dropped = 1'b0;
			end
		endfunction

		function void check_result(logic [hcmh_pkg::OUT_DATA_BITS-1:0] word);
			set_result_t want;
			logic [31:0] cost;
			logic [6:0]  count;
			logic        ovf;
			cost  = word[31:0];
			count = word[38:32];
			ovf   = word[39];
			if (owed.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t unexpected word: cost %0d count %0d ovf %0b",
						$time, cost, count, ovf);
				return;
			end
			want = owed.pop_front();
			if (cost !== want.cost || count !== want.count || ovf !== want.ovf) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t mismatch: cost exp %0d got %0d, count exp %0d got %0d, ovf exp %0b got %0b",
						$time, want.cost, cost, want.count, count, want.ovf, ovf);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	wire                                s_axis_tready;
	logic [W_BITS-1:0]                  s_axis_tdata = '0;
	logic                               s_axis_tlast = 1'b0;
	wire                                m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	wire  [hcmh_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;

	path_cost_book book = new;
	bit no_idle   = 1'b0;
	bit hold_req  = 1'b0;
	int hold_left = 0;
	int rx_left   = 0;
	bit rx_on     = 1'b0;
	int idle_run  = 0;
	int items_sent = 0;

	huffman_cost_min_heap dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// mostly short pauses, now and then a long one
	function int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function int send_gap();
		if (no_idle || $urandom_range(0, 1) == 0) return 0;
		return pause_len();
	endfunction

	function logic [W_BITS-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return W_BITS'($urandom_range(0, 15));
			5:       return W_BITS'($urandom_range(0, 255));
			default: return W_BITS'($urandom());
		endcase
	endfunction

	// offer one word and wait for it to be taken; tvalid stays high afterwards
	task push_weight(input logic [W_BITS-1:0] w, input logic closing);
		int gap;
		gap = send_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		s_axis_tlast  <= closing;
		do @(posedge clk); while (!s_axis_tready);
		book.note_weight(w, closing);
		items_sent++;
	endtask

	task send_set(input int n);
		logic [W_BITS-1:0] same;
		bit                all_same;
		all_same = ($urandom_range(0, 9) == 0);
		same = pick_weight();
		for (int i = 0; i < n; i++)
			push_weight(all_same ? same : pick_weight(), i == n - 1);
	endtask

	// sender stops until every owed result is out
	task drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// output side: check accepted words, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			book.check_result(m_axis_tdata);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_on   = !rx_on;
				rx_left = rx_on ? $urandom_range(1, 12) : pause_len();
			end
			rx_left--;
			m_axis_tready <= rx_on;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int sets_done;
		int size;
		int r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single symbols at both ends, extremes, equal weights, zeros
		push_weight(16'd0, 1'b1);
		push_weight(16'hFFFF, 1'b1);
		push_weight(16'd0, 1'b0);
		push_weight(16'hFFFF, 1'b1);
		for (int i = 0; i < 4; i++) push_weight(16'hFFFF, i == 3);
		for (int i = 0; i < 5; i++) push_weight(16'd1, i == 4);
		for (int i = 0; i < 3; i++) push_weight(16'd0, i == 2);
		push_weight(16'd5, 1'b0);
		push_weight(16'd9, 1'b0);
		push_weight(16'd12, 1'b0);
		push_weight(16'd13, 1'b0);
		push_weight(16'd16, 1'b0);
		push_weight(16'd45, 1'b1);
		drain_pause();

		// output held off while small sets keep coming, so the input backs up
		hold_req = 1'b1;
		no_idle  = 1'b1;
		for (int i = 0; i < 6; i++) send_set(3);
		no_idle = 1'b0;
		drain_pause();

		// random sets: mostly small, some medium, a few at or past heap capacity
		sets_done = 0;
		while (items_sent < ITEM_TARGET) begin
			if (sets_done % 12 == 0) no_idle = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (sets_done == 2)      size = HEAP_DEPTH;
			else if (sets_done == 5) size = HEAP_DEPTH + 1;
			else if (sets_done == 9) size = HEAP_DEPTH + 6;
			else if (r < 70)         size = $urandom_range(1, 8);
			else if (r < 93)         size = $urandom_range(9, 32);
			else                     size = $urandom_range(HEAP_DEPTH - 4, HEAP_DEPTH + 8);
			send_set(size);
			sets_done++;
			if ($urandom_range(0, 15) == 0) drain_pause();
		end
		no_idle = 1'b0;
		s_axis_tvalid <= 1'b0;

		// wait out the last merges, then a quiet stretch for stray words
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[huffman_cost_min_heap.f]
rtl/hcmh_pkg.sv
rtl/hcmh_heap_ram.sv
rtl/hcmh_alu.sv
rtl/huffman_cost_min_heap.sv
test/tb_huffman_cost_min_heap.sv
